// File: design/m32de_pkg.sv
// ============================================================================
// m32de_pkg
// Shared types and constants of the MIPS32 integer decode and execute unit.
// ============================================================================
`default_nettype none

package m32de_pkg;

    // Number of one-bit steps in the pipelined divider.
    localparam int DIV_STAGES = 32;

    // Operation numbers, dense in decode order, then float and undefined.
    typedef enum logic [6:0] {
        OP_NOP, OP_SSNOP, OP_SLL, OP_SRL, OP_SRA, OP_SLLV, OP_SRLV, OP_SRAV,
        OP_JR, OP_JRHB, OP_JALR, OP_JALRHB, OP_MOVZ, OP_MOVN, OP_SYSCALL,
        OP_BREAK, OP_SYNC, OP_MFHI, OP_MTHI, OP_MFLO, OP_MTLO, OP_MULT,
        OP_MULTU, OP_DIV, OP_DIVU, OP_ADD, OP_ADDU, OP_SUB, OP_SUBU, OP_AND,
        OP_OR, OP_XOR, OP_NOR, OP_SLT, OP_SLTU, OP_TGE, OP_TGEU, OP_TLT,
        OP_TLTU, OP_TEQ, OP_TNE, OP_BLTZ, OP_BGEZ, OP_BLTZL, OP_BGEZL,
        OP_TGEI, OP_TGEIU, OP_TLTI, OP_TLTIU, OP_TEQI, OP_TNEI, OP_BLTZAL,
        OP_BGEZAL, OP_BLTZALL, OP_BGEZALL, OP_J, OP_JAL, OP_BEQ, OP_BNE,
        OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI,
        OP_ORI, OP_XORI, OP_LUI, OP_MFC0, OP_CFC0, OP_MTC0, OP_TLBR, OP_TLBWI,
        OP_TLBWR, OP_TLBP, OP_ERET, OP_WAIT, OP_BEQL, OP_BNEL, OP_BLEZL,
        OP_BGTZL, OP_MADD, OP_MADDU, OP_MUL, OP_MSUB, OP_MSUBU, OP_CLZ, OP_CLO,
        OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH,
        OP_SWL, OP_SW, OP_SWR, OP_CACHE, OP_LL, OP_PREF, OP_SC, OP_FLOAT,
        OP_UNDEF
    } op_t;

    // Read mask bits.
    localparam logic [3:0] RD_NONE = 4'd0;
    localparam logic [3:0] RD_RS   = 4'd1;
    localparam logic [3:0] RD_RT   = 4'd2;
    localparam logic [3:0] RD_RSRT = 4'd3;
    localparam logic [3:0] RD_HI   = 4'd4;
    localparam logic [3:0] RD_LO   = 4'd8;
    localparam logic [3:0] RD_ALL  = 4'd15;

    // Write destinations.
    localparam logic [2:0] WD_NONE = 3'd0;
    localparam logic [2:0] WD_RD   = 3'd1;
    localparam logic [2:0] WD_RT   = 3'd2;
    localparam logic [2:0] WD_RDC  = 3'd3;
    localparam logic [2:0] WD_HI   = 3'd4;
    localparam logic [2:0] WD_LO   = 3'd5;
    localparam logic [2:0] WD_HILO = 3'd6;
    localparam logic [2:0] WD_RA   = 3'd7;

    // Branch kinds.
    localparam logic [1:0] BK_NONE   = 2'd0;
    localparam logic [1:0] BK_DELAY  = 2'd1;
    localparam logic [1:0] BK_LIKELY = 2'd2;
    localparam logic [1:0] BK_NOSLOT = 2'd3;

    // Memory access kinds.
    localparam logic [3:0] MK_NONE = 4'd0;
    localparam logic [3:0] MK_LB   = 4'd1;
    localparam logic [3:0] MK_LH   = 4'd2;
    localparam logic [3:0] MK_LW   = 4'd3;
    localparam logic [3:0] MK_LWU  = 4'd4;
    localparam logic [3:0] MK_SB   = 4'd5;
    localparam logic [3:0] MK_SH   = 4'd6;
    localparam logic [3:0] MK_SW   = 4'd7;
    localparam logic [3:0] MK_SWU  = 4'd8;

    // Status codes.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_SYSCALL = 2'd1;
    localparam logic [1:0] ST_UNSUP   = 2'd2;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [31:0] pc_value;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
    } item_t;

    typedef struct packed {
        logic [6:0]  op_id;
        logic [3:0]  read_mask;
        logic [2:0]  write_dest;
        logic [1:0]  branch_kind;
        logic [3:0]  mem_kind;
        logic [31:0] result_word;
        logic [63:0] result_hilo;
        logic [31:0] next_pc;
        logic        condition;
        logic [31:0] mem_address;
        logic [1:0]  status;
    } result_t;

    // Work in flight between the decode stage and the final stage.
    typedef struct packed {
        result_t     res;
        op_t         op;
        logic [31:0] rs;
        logic [31:0] rt;
        logic [63:0] acc;
        logic [15:0] lz;
        logic        mul_sgn;
        logic [63:0] prod;
        logic        neg_q;
        logic        neg_r;
        logic        div_ok;
    } stage_t;

    typedef struct packed {
        logic [3:0] rm;
        logic [2:0] wd;
        logic [1:0] bk;
        logic [3:0] mk;
    } attr_t;

    // Operand, destination, branch and memory attributes of each operation.
    function automatic attr_t op_attr(input op_t op);
        attr_t a;
        a = '{RD_NONE, WD_NONE, BK_NONE, MK_NONE};
        case (op) inside
            OP_SLL, OP_SRL, OP_SRA:             a = '{RD_RT, WD_RD, BK_NONE, MK_NONE};
            OP_SLLV, OP_SRLV, OP_SRAV, OP_MUL:  a = '{RD_RSRT, WD_RD, BK_NONE, MK_NONE};
            [OP_ADD:OP_SLTU]:                   a = '{RD_RSRT, WD_RD, BK_NONE, MK_NONE};
            OP_JR, OP_JRHB, OP_BLTZ, OP_BGEZ,
            OP_BLEZ, OP_BGTZ:                   a = '{RD_RS, WD_NONE, BK_DELAY, MK_NONE};
            OP_JALR, OP_JALRHB:                 a = '{RD_RS, WD_RD, BK_DELAY, MK_NONE};
            OP_MOVZ, OP_MOVN:                   a = '{RD_RSRT, WD_RDC, BK_NONE, MK_NONE};
            OP_MFHI:                            a = '{RD_HI, WD_RD, BK_NONE, MK_NONE};
            OP_MTHI:                            a = '{RD_RS, WD_HI, BK_NONE, MK_NONE};
            OP_MFLO:                            a = '{RD_LO, WD_RD, BK_NONE, MK_NONE};
            OP_MTLO:                            a = '{RD_RS, WD_LO, BK_NONE, MK_NONE};
            [OP_MULT:OP_DIVU]:                  a = '{RD_RSRT, WD_HILO, BK_NONE, MK_NONE};
            [OP_TGE:OP_TNE]:                    a = '{RD_RSRT, WD_NONE, BK_NONE, MK_NONE};
            OP_BLTZL, OP_BGEZL, OP_BLEZL,
            OP_BGTZL:                           a = '{RD_RS, WD_NONE, BK_LIKELY, MK_NONE};
            [OP_TGEI:OP_TNEI], OP_CACHE,
            OP_PREF:                            a = '{RD_RS, WD_NONE, BK_NONE, MK_NONE};
            OP_BLTZAL, OP_BGEZAL:               a = '{RD_RS, WD_RA, BK_DELAY, MK_NONE};
            OP_BLTZALL, OP_BGEZALL:             a = '{RD_RS, WD_RA, BK_LIKELY, MK_NONE};
            OP_J:                               a = '{RD_NONE, WD_NONE, BK_DELAY, MK_NONE};
            OP_JAL:                             a = '{RD_NONE, WD_RA, BK_DELAY, MK_NONE};
            OP_BEQ, OP_BNE:                     a = '{RD_RSRT, WD_NONE, BK_DELAY, MK_NONE};
            OP_BEQL, OP_BNEL:                   a = '{RD_RSRT, WD_NONE, BK_LIKELY, MK_NONE};
            [OP_ADDI:OP_XORI]:                  a = '{RD_RS, WD_RT, BK_NONE, MK_NONE};
            OP_LUI, OP_MFC0, OP_CFC0:           a = '{RD_NONE, WD_RT, BK_NONE, MK_NONE};
            OP_MTC0:                            a = '{RD_RT, WD_NONE, BK_NONE, MK_NONE};
            OP_ERET:                            a = '{RD_NONE, WD_NONE, BK_NOSLOT, MK_NONE};
            OP_MADD, OP_MADDU, OP_MSUB,
            OP_MSUBU:                           a = '{RD_ALL, WD_HILO, BK_NONE, MK_NONE};
            OP_CLZ, OP_CLO:                     a = '{RD_RS, WD_RD, BK_NONE, MK_NONE};
            OP_LB, OP_LBU:                      a = '{RD_RS, WD_RT, BK_NONE, MK_LB};
            OP_LH, OP_LHU:                      a = '{RD_RS, WD_RT, BK_NONE, MK_LH};
            OP_LWL, OP_LWR:                     a = '{RD_RSRT, WD_RT, BK_NONE, MK_LWU};
            OP_LW, OP_LL:                       a = '{RD_RS, WD_RT, BK_NONE, MK_LW};
            OP_SB:                              a = '{RD_RSRT, WD_NONE, BK_NONE, MK_SB};
            OP_SH:                              a = '{RD_RSRT, WD_NONE, BK_NONE, MK_SH};
            OP_SWL, OP_SWR:                     a = '{RD_RSRT, WD_NONE, BK_NONE, MK_SWU};
            OP_SW:                              a = '{RD_RSRT, WD_NONE, BK_NONE, MK_SW};
            OP_SC:                              a = '{RD_RSRT, WD_RT, BK_NONE, MK_SW};
            default:                            a = '{RD_NONE, WD_NONE, BK_NONE, MK_NONE};
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: design/mips32_decode_execute.sv
// ============================================================================
// mips32_decode_execute
// MIPS32 integer decode and execute unit, fully pipelined.
// ============================================================================
// One instruction is taken on every cycle that start is high; busy is always
// low. Each beat comes out on result in order, marked by a one-cycle done
// strobe, once it has passed the decode stage, the 32-stage divider (one
// quotient bit per stage) and the final sign-fix stage; multiply,
// accumulate and count-leading work ride along in the same pipeline.
// The receiver must take every beat.
`default_nettype none

module mips32_decode_execute (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire m32de_pkg::item_t  item,
    output logic                   done,
    output m32de_pkg::result_t     result
);
    import m32de_pkg::*;

    stage_t      dec_reg;
    logic        dec_vld_reg;
    stage_t      side_reg [DIV_STAGES];
    logic        side_vld_reg [DIV_STAGES];
    stage_t      side_next [DIV_STAGES];
    stage_t      mul_p, mul_a;
    logic [31:0] div_num, div_den, div_quo, div_rem, q_fix, r_fix;
    stage_t      last;
    logic [5:0]  lz_sum;
    result_t     result_reg, result_next;
    logic        done_reg;

    assign busy = 1'b0;

    m32de_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (start),
        .item        (item),
        .dec_reg     (dec_reg),
        .dec_vld_reg (dec_vld_reg)
    );

    // Divider runs on magnitudes; signs are fixed at the end.
    assign div_num = dec_reg.neg_r ? (32'd0 - dec_reg.rs) : dec_reg.rs;
    assign div_den = (dec_reg.op == OP_DIV && dec_reg.rt[31]) ? (32'd0 - dec_reg.rt)
                                                               : dec_reg.rt;

    m32de_div u_div (
        .clk (clk),
        .num (div_num),
        .den (div_den),
        .quo (div_quo),
        .rem (div_rem)
    );

    m32de_mul u_mul (
        .src      (dec_reg),
        .mid      (side_reg[0]),
        .prod_out (mul_p),
        .acc_out  (mul_a)
    );

    // Combine the per-byte leading counts.
    always_comb
    begin
        if (dec_reg.lz[15:12] != 4'd8)     lz_sum = {2'b00, dec_reg.lz[15:12]};
        else if (dec_reg.lz[11:8] != 4'd8) lz_sum = 6'd8 + {2'b00, dec_reg.lz[11:8]};
        else if (dec_reg.lz[7:4] != 4'd8)  lz_sum = 6'd16 + {2'b00, dec_reg.lz[7:4]};
        else                               lz_sum = 6'd24 + {2'b00, dec_reg.lz[3:0]};
    end

    // Side line that keeps each beat level with the divider.
    always_comb
    begin
        side_next[0] = mul_p;
        if (dec_reg.op == OP_CLZ || dec_reg.op == OP_CLO)
        begin
            side_next[0].res.result_word = {26'd0, lz_sum};
        end
        side_next[1] = mul_a;
        for (int i = 2; i < DIV_STAGES; i++)
        begin
            side_next[i] = side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++) side_vld_reg[i] <= 1'b0;
        end
        else
        begin
            side_vld_reg[0] <= dec_vld_reg;
            for (int i = 1; i < DIV_STAGES; i++) side_vld_reg[i] <= side_vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DIV_STAGES; i++) side_reg[i] <= side_next[i];
    end

    // Final stage: signs of quotient and remainder, zero on a bad divide.
    assign last  = side_reg[DIV_STAGES-1];
    assign q_fix = last.neg_q ? (32'd0 - div_quo) : div_quo;
    assign r_fix = last.neg_r ? (32'd0 - div_rem) : div_rem;

    always_comb
    begin
        result_next = last.res;
        if ((last.op == OP_DIV || last.op == OP_DIVU) && last.div_ok)
        begin
            result_next.result_hilo = {r_fix, q_fix};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= side_vld_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A beat leaves the final stage exactly when one left the side line.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(side_vld_reg[DIV_STAGES-1]))
        else $error("done strobe out of step with the pipeline");

    // An unsupported encoding carries no results.
    a_unsup_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == ST_UNSUP) |->
            (result.result_word == 32'd0 && result.result_hilo == 64'd0
             && result.next_pc == 32'd0 && result.read_mask == RD_NONE))
        else $error("unsupported instruction produced a result");

    // Every beat carries one of the three defined status codes.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_DONE || result.status == ST_SYSCALL
                  || result.status == ST_UNSUP))
        else $error("invalid status code");

    // A memory access always writes rt or nothing, never rd.
    a_mem_dest: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.mem_kind != MK_NONE) |->
            (result.write_dest == WD_RT || result.write_dest == WD_NONE))
        else $error("memory access with a register destination other than rt");

endmodule

`default_nettype wire

// File: design/m32de_decode.sv
// ============================================================================
// m32de_decode
// First pipeline stage: decodes the instruction word and computes all
// results that need no later stage; multiply, divide and count-leading work follow later.
// ============================================================================
`default_nettype none

module m32de_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_vld,
    input  wire m32de_pkg::item_t item,
    output m32de_pkg::stage_t    dec_reg,
    output logic                 dec_vld_reg
);
    import m32de_pkg::*;

    logic [31:0] w, pc, rs, rt, simm, btarget, pc8, pc4, rs_lz;
    logic [5:0]  opc, fn;
    logic [4:0]  f_rs, f_rt, f_rd, f_sh;
    op_t         op;
    attr_t       at;
    stage_t      dec_next;

    // Leading zero count of one byte, 0 to 8.
    function automatic logic [3:0] lz8(input logic [7:0] b);
        logic [3:0] n;
        logic       hit;
        n   = 4'd0;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit && !b[i]) n = n + 4'd1;
            else hit = 1'b1;
        end
        return n;
    endfunction

    assign w     = item.instr_word;
    assign pc    = item.pc_value;
    assign rs    = item.rs_value;
    assign rt    = item.rt_value;
    assign opc   = w[31:26];
    assign f_rs  = w[25:21];
    assign f_rt  = w[20:16];
    assign f_rd  = w[15:11];
    assign f_sh  = w[10:6];
    assign fn    = w[5:0];
    assign simm  = {{16{w[15]}}, w[15:0]};
    assign pc4   = pc + 32'd4;
    assign pc8   = pc + 32'd8;
    assign btarget = pc4 + {simm[29:0], 2'b00};

    // Operation decode.
    always_comb
    begin
        op = OP_UNDEF;
        case (opc)
            6'd0:
            begin
                case (fn)
                    6'd0:
                    begin
                        if ((f_rt | f_rd | f_sh) == 5'd0) op = OP_NOP;
                        else if ((f_rt | f_rd) == 5'd0 && f_sh == 5'd1) op = OP_SSNOP;
                        else op = OP_SLL;
                    end
                    6'd1:  op = OP_FLOAT;
                    6'd2:  op = OP_SRL;
                    6'd3:  op = OP_SRA;
                    6'd4:  op = OP_SLLV;
                    6'd6:  op = OP_SRLV;
                    6'd7:  op = OP_SRAV;
                    6'd8:  op = (f_sh == 5'd0) ? OP_JR : ((f_sh == 5'd16) ? OP_JRHB : OP_UNDEF);
                    6'd9:  op = (f_sh == 5'd0) ? OP_JALR
                                : ((f_sh == 5'd16) ? OP_JALRHB : OP_UNDEF);
                    6'd10: op = OP_MOVZ;
                    6'd11: op = OP_MOVN;
                    6'd12: op = OP_SYSCALL;
                    6'd13: op = OP_BREAK;
                    6'd15: op = OP_SYNC;
                    6'd16: op = OP_MFHI;
                    6'd17: op = OP_MTHI;
                    6'd18: op = OP_MFLO;
                    6'd19: op = OP_MTLO;
                    6'd24: op = OP_MULT;
                    6'd25: op = OP_MULTU;
                    6'd26: op = OP_DIV;
                    6'd27: op = OP_DIVU;
                    6'd32: op = OP_ADD;
                    6'd33: op = OP_ADDU;
                    6'd34: op = OP_SUB;
                    6'd35: op = OP_SUBU;
                    6'd36: op = OP_AND;
                    6'd37: op = OP_OR;
                    6'd38: op = OP_XOR;
                    6'd39: op = OP_NOR;
                    6'd42: op = OP_SLT;
                    6'd43: op = OP_SLTU;
                    6'd48: op = OP_TGE;
                    6'd49: op = OP_TGEU;
                    6'd50: op = OP_TLT;
                    6'd51: op = OP_TLTU;
                    6'd52: op = OP_TEQ;
                    6'd54: op = OP_TNE;
                    default: op = OP_UNDEF;
                endcase
            end
            6'd1:
            begin
                case (f_rt)
                    5'd0:  op = OP_BLTZ;
                    5'd1:  op = OP_BGEZ;
                    5'd2:  op = OP_BLTZL;
                    5'd3:  op = OP_BGEZL;
                    5'd8:  op = OP_TGEI;
                    5'd9:  op = OP_TGEIU;
                    5'd10: op = OP_TLTI;
                    5'd11: op = OP_TLTIU;
                    5'd12: op = OP_TEQI;
                    5'd14: op = OP_TNEI;
                    5'd16: op = OP_BLTZAL;
                    5'd17: op = OP_BGEZAL;
                    5'd18: op = OP_BLTZALL;
                    5'd19: op = OP_BGEZALL;
                    default: op = OP_UNDEF;
                endcase
            end
            6'd2:  op = OP_J;
            6'd3:  op = OP_JAL;
            6'd4:  op = OP_BEQ;
            6'd5:  op = OP_BNE;
            6'd6:  op = OP_BLEZ;
            6'd7:  op = OP_BGTZ;
            6'd8:  op = OP_ADDI;
            6'd9:  op = OP_ADDIU;
            6'd10: op = OP_SLTI;
            6'd11: op = OP_SLTIU;
            6'd12: op = OP_ANDI;
            6'd13: op = OP_ORI;
            6'd14: op = OP_XORI;
            6'd15: op = OP_LUI;
            6'd16:
            begin
                if (f_rs == 5'd0) op = OP_MFC0;
                else if (f_rs == 5'd2) op = OP_CFC0;
                else if (f_rs == 5'd4) op = OP_MTC0;
                else if (f_rs == 5'd16)
                begin
                    case (fn)
                        6'd1:  op = OP_TLBR;
                        6'd2:  op = OP_TLBWI;
                        6'd6:  op = OP_TLBWR;
                        6'd8:  op = OP_TLBP;
                        6'd24: op = OP_ERET;
                        6'd32: op = OP_WAIT;
                        default: op = OP_UNDEF;
                    endcase
                end
            end
            6'd20: op = OP_BEQL;
            6'd21: op = OP_BNEL;
            6'd22: op = OP_BLEZL;
            6'd23: op = OP_BGTZL;
            6'd28:
            begin
                case (fn)
                    6'd0:  op = OP_MADD;
                    6'd1:  op = OP_MADDU;
                    6'd2:  op = OP_MUL;
                    6'd4:  op = OP_MSUB;
                    6'd5:  op = OP_MSUBU;
                    6'd32: op = OP_CLZ;
                    6'd33: op = OP_CLO;
                    default: op = OP_UNDEF;
                endcase
            end
            6'd32: op = OP_LB;
            6'd33: op = OP_LH;
            6'd34: op = OP_LWL;
            6'd35: op = OP_LW;
            6'd36: op = OP_LBU;
            6'd37: op = OP_LHU;
            6'd38: op = OP_LWR;
            6'd40: op = OP_SB;
            6'd41: op = OP_SH;
            6'd42: op = OP_SWL;
            6'd43: op = OP_SW;
            6'd46: op = OP_SWR;
            6'd47: op = OP_CACHE;
            6'd48: op = OP_LL;
            6'd51: op = OP_PREF;
            6'd56: op = OP_SC;
            6'd17, 6'd19, 6'd49, 6'd53, 6'd57, 6'd61: op = OP_FLOAT;
            default: op = OP_UNDEF;
        endcase
    end

    assign at    = op_attr(op);
    assign rs_lz = (op == OP_CLO) ? ~rs : rs;

    // Results done in this stage; the later stages fill in multiply, divide and counts.
    always_comb
    begin
        dec_next = '0;
        dec_next.op      = op;
        dec_next.rs      = rs;
        dec_next.rt      = rt;
        dec_next.acc     = {item.hi_value, item.lo_value};
        dec_next.lz      = {lz8(rs_lz[31:24]), lz8(rs_lz[23:16]),
                            lz8(rs_lz[15:8]), lz8(rs_lz[7:0])};
        dec_next.mul_sgn = (op == OP_MULT) || (op == OP_MADD) || (op == OP_MSUB);
        dec_next.neg_q   = (op == OP_DIV) && (rs[31] != rt[31]);
        dec_next.neg_r   = (op == OP_DIV) && rs[31];
        dec_next.div_ok  = (rt != 32'd0)
                           && !(op == OP_DIV && rs == 32'h8000_0000 && rt == 32'hffff_ffff);
        dec_next.res.op_id       = op;
        dec_next.res.read_mask   = at.rm;
        dec_next.res.write_dest  = at.wd;
        dec_next.res.branch_kind = at.bk;
        dec_next.res.mem_kind    = at.mk;
        case (op)
            OP_SLL:  dec_next.res.result_word = rt << f_sh;
            OP_SRL:  dec_next.res.result_word = rt >> f_sh;
            OP_SRA:  dec_next.res.result_word = $unsigned($signed(rt) >>> f_sh);
            OP_SLLV: dec_next.res.result_word = rt << rs[4:0];
            OP_SRLV: dec_next.res.result_word = rt >> rs[4:0];
            OP_SRAV: dec_next.res.result_word = $unsigned($signed(rt) >>> rs[4:0]);
            OP_JR, OP_JRHB:
            begin
                dec_next.res.next_pc   = rs;
                dec_next.res.condition = 1'b1;
            end
            OP_JALR, OP_JALRHB:
            begin
                dec_next.res.result_word = pc8;
                dec_next.res.next_pc     = rs;
                dec_next.res.condition   = 1'b1;
            end
            OP_MOVZ:
            begin
                dec_next.res.result_word = rs;
                dec_next.res.condition   = (rt == 32'd0);
            end
            OP_MOVN:
            begin
                dec_next.res.result_word = rs;
                dec_next.res.condition   = (rt != 32'd0);
            end
            OP_SYSCALL: dec_next.res.status = ST_SYSCALL;
            OP_MFHI: dec_next.res.result_word = item.hi_value;
            OP_MTHI: dec_next.res.result_hilo = {rs, item.lo_value};
            OP_MFLO: dec_next.res.result_word = item.lo_value;
            OP_MTLO: dec_next.res.result_hilo = {item.hi_value, rs};
            OP_ADD, OP_ADDU: dec_next.res.result_word = rs + rt;
            OP_SUB, OP_SUBU: dec_next.res.result_word = rs - rt;
            OP_AND:  dec_next.res.result_word = rs & rt;
            OP_OR:   dec_next.res.result_word = rs | rt;
            OP_XOR:  dec_next.res.result_word = rs ^ rt;
            OP_NOR:  dec_next.res.result_word = ~(rs | rt);
            OP_SLT:  dec_next.res.result_word = {31'd0, $signed(rs) < $signed(rt)};
            OP_SLTU: dec_next.res.result_word = {31'd0, rs < rt};
            OP_BLTZ, OP_BLTZL, OP_BLTZAL, OP_BLTZALL:
            begin
                dec_next.res.next_pc     = btarget;
                dec_next.res.condition   = rs[31];
                dec_next.res.result_word = pc8;
            end
            OP_BGEZ, OP_BGEZL, OP_BGEZAL, OP_BGEZALL:
            begin
                dec_next.res.next_pc     = btarget;
                dec_next.res.condition   = !rs[31];
                dec_next.res.result_word = pc8;
            end
            OP_J:
            begin
                dec_next.res.next_pc   = {pc4[31:28], w[25:0], 2'b00};
                dec_next.res.condition = 1'b1;
            end
            OP_JAL:
            begin
                dec_next.res.next_pc     = {pc4[31:28], w[25:0], 2'b00};
                dec_next.res.condition   = 1'b1;
                dec_next.res.result_word = pc8;
            end
            OP_BEQ, OP_BEQL:
            begin
                dec_next.res.next_pc   = btarget;
                dec_next.res.condition = (rs == rt);
            end
            OP_BNE, OP_BNEL:
            begin
                dec_next.res.next_pc   = btarget;
                dec_next.res.condition = (rs != rt);
            end
            OP_BLEZ, OP_BLEZL:
            begin
                dec_next.res.next_pc   = btarget;
                dec_next.res.condition = (rs == 32'd0) || rs[31];
            end
            OP_BGTZ, OP_BGTZL:
            begin
                dec_next.res.next_pc   = btarget;
                dec_next.res.condition = (rs != 32'd0) && !rs[31];
            end
            OP_ADDI, OP_ADDIU: dec_next.res.result_word = rs + simm;
            OP_SLTI:  dec_next.res.result_word = {31'd0, $signed(rs) < $signed(simm)};
            OP_SLTIU: dec_next.res.result_word = {31'd0, rs < simm};
            OP_ANDI:  dec_next.res.result_word = rs & {16'd0, w[15:0]};
            OP_ORI:   dec_next.res.result_word = rs | {16'd0, w[15:0]};
            OP_XORI:  dec_next.res.result_word = rs ^ {16'd0, w[15:0]};
            OP_LUI:   dec_next.res.result_word = {w[15:0], 16'd0};
            OP_MTC0:  dec_next.res.result_word = rt;
            OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH,
            OP_SWL, OP_SW, OP_SWR, OP_LL, OP_SC:
            begin
                dec_next.res.mem_address = rs + simm;
                dec_next.res.result_word = rt;
            end
            OP_FLOAT, OP_UNDEF: dec_next.res.status = ST_UNSUP;
            default: ;
        endcase
    end

    // Stage register; only the valid bit needs a reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) dec_vld_reg <= 1'b0;
        else        dec_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

endmodule

`default_nettype wire

// File: design/m32de_div.sv
// ============================================================================
// m32de_div
// Pipelined unsigned restoring divider: one quotient bit per stage, a new
// dividend and divisor pair may enter every cycle.
// ============================================================================
`default_nettype none

module m32de_div (
    input  wire logic        clk,
    input  wire logic [31:0] num,
    input  wire logic [31:0] den,
    output logic [31:0]      quo,
    output logic [31:0]      rem
);
    import m32de_pkg::*;

    logic [31:0] num_reg [DIV_STAGES];
    logic [31:0] den_reg [DIV_STAGES];
    logic [31:0] rem_reg [DIV_STAGES];
    logic [31:0] quo_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_step
            logic [31:0] num_in, den_in, rem_in, quo_in;
            logic [32:0] trial, diff;

            // Stage zero starts from the operands with a clear remainder.
            if (k == 0)
            begin : g_first
                assign num_in = num;
                assign den_in = den;
                assign rem_in = '0;
                assign quo_in = '0;
            end
            else
            begin : g_next
                assign num_in = num_reg[k-1];
                assign den_in = den_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign quo_in = quo_reg[k-1];
            end

            // Shift in the next dividend bit and subtract when it fits.
            assign trial = {rem_in, num_in[31]};
            assign diff  = trial - {1'b0, den_in};

            always_ff @(posedge clk)
            begin
                num_reg[k] <= {num_in[30:0], 1'b0};
                den_reg[k] <= den_in;
                rem_reg[k] <= diff[32] ? trial[31:0] : diff[31:0];
                quo_reg[k] <= {quo_in[30:0], !diff[32]};
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STAGES-1];
    assign rem = rem_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// File: design/m32de_mul.sv
// ============================================================================
// m32de_mul
// Two-stage multiply unit: a registered 33x33 product, then the HI/LO
// accumulate or subtract and the MUL low word.
// ============================================================================
`default_nettype none

module m32de_mul (
    input  wire m32de_pkg::stage_t src,
    input  wire m32de_pkg::stage_t mid,
    output m32de_pkg::stage_t      prod_out,
    output m32de_pkg::stage_t      acc_out
);
    import m32de_pkg::*;

    logic signed [32:0] a_ext, b_ext;
    logic signed [65:0] p_full;

    assign a_ext  = $signed({src.mul_sgn & src.rs[31], src.rs});
    assign b_ext  = $signed({src.mul_sgn & src.rt[31], src.rt});
    assign p_full = a_ext * b_ext;

    // First stage: attach the product to the item.
    always_comb
    begin
        prod_out = src;
        prod_out.prod = p_full[63:0];
    end

    // Second stage: fold the product into the result.
    always_comb
    begin
        acc_out = mid;
        case (mid.op)
            OP_MULT, OP_MULTU: acc_out.res.result_hilo = mid.prod;
            OP_MADD, OP_MADDU: acc_out.res.result_hilo = mid.acc + mid.prod;
            OP_MSUB, OP_MSUBU: acc_out.res.result_hilo = mid.acc - mid.prod;
            OP_MUL:            acc_out.res.result_word = mid.prod[31:0];
            default: ;
        endcase
    end

endmodule

`default_nettype wire
